/* rtl/rsp_pkg.sv */
package rsp_pkg;

    // Flag bytes that open a packet
    localparam logic [7:0] FLAG_DATA     = 8'd1;
    localparam logic [7:0] FLAG_CONTROL  = 8'd2;
    localparam logic [7:0] FLAG_INIT     = 8'd4;
    localparam logic [7:0] FLAG_CONTINUE = 8'd16;

    // Control packet layout
    localparam logic [7:0] OPCODE_END     = 8'd64;
    localparam logic [3:0] CIDX_FIRST     = 4'd1;
    localparam logic [3:0] CIDX_OPCODE    = 4'd2;
    localparam logic [3:0] CIDX_SUCCESS   = 4'd3;
    localparam logic [3:0] CIDX_COUNT_LO  = 4'd8;
    localparam logic [3:0] CIDX_COUNT_HI  = 4'd9;
    localparam logic [3:0] CIDX_STATUS_LO = 4'd10;
    localparam logic [3:0] CIDX_STATUS_HI = 4'd11;

    // Result kinds
    localparam logic [3:0] KIND_PAYLOAD     = 4'd0;
    localparam logic [3:0] KIND_DATA_OK     = 4'd1;
    localparam logic [3:0] KIND_DATA_BAD    = 4'd2;
    localparam logic [3:0] KIND_END_OK      = 4'd3;
    localparam logic [3:0] KIND_CTRL_NOTEND = 4'd4;
    localparam logic [3:0] KIND_CTRL_BAD    = 4'd5;
    localparam logic [3:0] KIND_CONTINUE    = 4'd6;
    localparam logic [3:0] KIND_INIT        = 4'd7;
    localparam logic [3:0] KIND_UNEXPECTED  = 4'd8;

    // Framing phase of the front end
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DCOUNT,
        PH_DPAY,
        PH_DCKLO,
        PH_DCKHI,
        PH_CBODY,
        PH_CCKLO,
        PH_CCKHI
    } phase_t;

    // Operation handed from the front end to the back end
    typedef enum logic [3:0] {
        OP_START,
        OP_SUM,
        OP_PAYLOAD,
        OP_CTRL_BYTE,
        OP_CHECK_LO,
        OP_DATA_CHECK,
        OP_CTRL_CHECK,
        OP_FLAG_CONTINUE,
        OP_FLAG_INIT,
        OP_FLAG_BAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [3:0] idx;
    } cmd_t;

endpackage

/* rtl/rsp_packet_receiver_core.sv */
// Packet receiver for a radial serial protocol byte stream. Each accepted
// request on the s_ channel is one received byte; the block frames packets
// by their flag byte (data, control, continue, init, anything else is an
// unexpected flag), forwards data payload bytes as they arrive (kind 0,
// last low) and closes every packet with one result carrying the checksum
// verdict (last high). The checksum is a little-endian 16-bit word sum with
// end-around carry over all bytes before the check bytes. An END control
// packet with a good checksum reports its byte count, signed success code
// and status; all fields a result kind does not use read as zero. Bytes
// that cause no result (flag, count, control body, check low byte) yield
// nothing on the m_ channel. Rate is one byte per clock while m_ready
// stays high, sustained without bubbles: the framer takes a byte in the
// cycle it arrives and posts an operation to a QUEUE_DEPTH-entry queue;
// the executor drains one operation per clock into the output register
// while it is free. The queue lets the framer keep taking bytes while
// m_ready is low, until it fills; s_ready drops only then.
module rsp_packet_receiver_core
    import rsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [3:0]        m_kind,
    output logic [7:0]        m_payload_byte,
    output logic [15:0]       m_end_byte_count,
    output logic signed [7:0] m_end_success_code,
    output logic [15:0]       m_end_status,
    output logic [15:0]       m_computed_checksum,
    output logic              m_last
);

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic front_push;
    logic queue_ready;
    logic queue_valid;
    logic back_pop;

    // Framer: track packet phase, classify each byte
    rsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .rx_byte    (s_rx_byte),
        .push_ready (queue_ready),
        .push       (front_push),
        .cmd        (front_cmd)
    );

    // Hold operations between framer and executor
    rsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_push),
        .push_ready (queue_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop        (back_pop),
        .pop_cmd    (back_cmd)
    );

    // Executor: accumulate checksum, capture control fields, drive results
    rsp_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd_valid           (queue_valid),
        .cmd_pop             (back_pop),
        .cmd                 (back_cmd),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_payload_byte      (m_payload_byte),
        .m_end_byte_count    (m_end_byte_count),
        .m_end_success_code  (m_end_success_code),
        .m_end_status        (m_end_status),
        .m_computed_checksum (m_computed_checksum),
        .m_last              (m_last)
    );

    // Payload results never close a packet; every other kind does
    a_last_matches_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_kind != KIND_PAYLOAD)))
        else $error("last flag disagrees with result kind");

    // END fields stay zero unless the result is an END report
    a_end_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind != KIND_END_OK)) |->
            ((m_end_byte_count == 16'd0) && (m_end_status == 16'd0) &&
             (m_end_success_code == 8'sd0)))
        else $error("END fields set on a non-END result");

    // A payload result carries no checksum
    a_payload_no_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_PAYLOAD)) |-> (m_computed_checksum == 16'd0))
        else $error("payload result carries a checksum");

    // Queue drains every cycle the output side is free
    a_queue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (queue_valid && (!m_valid || m_ready)) |-> back_pop)
        else $error("executor stalled with a free output register");

endmodule

/* rtl/rsp_front.sv */
module rsp_front
    import rsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       push_ready,
    output logic       push,
    output cmd_t       cmd
);

    phase_t     phase_reg, phase_next;
    logic [7:0] remain_reg, remain_next;
    logic [3:0] index_reg, index_next;
    logic       take;

    assign in_ready = push_ready;
    assign take     = in_valid && push_ready;
    assign push     = take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            remain_reg <= '0;
            index_reg  <= '0;
        end else if (take) begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            index_reg  <= index_next;
        end
    end

    // Frame the byte and pick the operation for the back end
    always_comb begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        index_next  = index_reg;
        cmd.op      = OP_SUM;
        cmd.data    = rx_byte;
        cmd.idx     = index_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == FLAG_DATA) begin
                    cmd.op     = OP_START;
                    phase_next = PH_DCOUNT;
                end else if (rx_byte == FLAG_CONTROL) begin
                    cmd.op     = OP_START;
                    index_next = CIDX_FIRST;
                    phase_next = PH_CBODY;
                end else if (rx_byte == FLAG_CONTINUE) begin
                    cmd.op = OP_FLAG_CONTINUE;
                end else if (rx_byte == FLAG_INIT) begin
                    cmd.op = OP_FLAG_INIT;
                end else begin
                    cmd.op = OP_FLAG_BAD;
                end
            end
            PH_DCOUNT: begin
                cmd.op      = OP_SUM;
                remain_next = rx_byte;
                phase_next  = (rx_byte != 8'd0) ? PH_DPAY : PH_DCKLO;
            end
            PH_DPAY: begin
                cmd.op      = OP_PAYLOAD;
                remain_next = remain_reg - 8'd1;
                if (remain_reg == 8'd1) begin
                    phase_next = PH_DCKLO;
                end
            end
            PH_DCKLO: begin
                cmd.op     = OP_CHECK_LO;
                phase_next = PH_DCKHI;
            end
            PH_DCKHI: begin
                cmd.op     = OP_DATA_CHECK;
                phase_next = PH_IDLE;
            end
            PH_CBODY: begin
                cmd.op     = OP_CTRL_BYTE;
                index_next = index_reg + 4'd1;
                if (index_reg >= CIDX_STATUS_HI) begin
                    phase_next = PH_CCKLO;
                end
            end
            PH_CCKLO: begin
                cmd.op     = OP_CHECK_LO;
                phase_next = PH_CCKHI;
            end
            PH_CCKHI: begin
                cmd.op     = OP_CTRL_CHECK;
                index_next = '0;
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

/* rtl/rsp_queue.sv */
module rsp_queue
    import rsp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/rsp_back.sv */
module rsp_back
    import rsp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  cmd_t              cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [3:0]        m_kind,
    output logic [7:0]        m_payload_byte,
    output logic [15:0]       m_end_byte_count,
    output logic signed [7:0] m_end_success_code,
    output logic [15:0]       m_end_status,
    output logic [15:0]       m_computed_checksum,
    output logic              m_last
);

    // Checksum state
    logic [15:0] acc_reg, acc_next;
    logic        odd_reg, odd_next;
    logic [7:0]  pending_reg, pending_next;
    logic [7:0]  check_lo_reg, check_lo_next;
    // Control packet fields
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  success_reg, success_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] status_reg, status_next;
    // Result register
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  kind_reg, kind_next;
    logic [7:0]  pay_reg, pay_next;
    logic [15:0] ecount_reg, ecount_next;
    logic [7:0]  esucc_reg, esucc_next;
    logic [15:0] estatus_reg, estatus_next;
    logic [15:0] csum_reg, csum_next;
    logic        last_reg, last_next;

    logic [15:0] addend;
    logic [16:0] raw_sum;
    logic [15:0] folded_sum;
    logic [15:0] received_sum;
    logic        sum_match;

    assign cmd_pop = cmd_valid && (!out_valid_reg || m_ready);

    // End-around carry add; a lone trailing byte goes in as a low byte
    assign addend       = (cmd.op == OP_CHECK_LO) ? {8'h00, pending_reg} : {cmd.data, pending_reg};
    assign raw_sum      = {1'b0, acc_reg} + {1'b0, addend};
    assign folded_sum   = raw_sum[16] ? (raw_sum[15:0] + 16'd1) : raw_sum[15:0];
    assign received_sum = {cmd.data, check_lo_reg};
    assign sum_match    = (acc_reg == received_sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            odd_reg       <= odd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pending_reg  <= pending_next;
        check_lo_reg <= check_lo_next;
        opcode_reg   <= opcode_next;
        success_reg  <= success_next;
        count_reg    <= count_next;
        status_reg   <= status_next;
        kind_reg     <= kind_next;
        pay_reg      <= pay_next;
        ecount_reg   <= ecount_next;
        esucc_reg    <= esucc_next;
        estatus_reg  <= estatus_next;
        csum_reg     <= csum_next;
        last_reg     <= last_next;
    end

    always_comb begin
        logic       emit;
        logic       sum_in;
        logic [3:0] rkind;
        logic [7:0] rpay;
        logic [15:0] rcount;
        logic [7:0] rsucc;
        logic [15:0] rstatus;
        logic [15:0] rcsum;
        logic       rlast;

        acc_next      = acc_reg;
        odd_next      = odd_reg;
        pending_next  = pending_reg;
        check_lo_next = check_lo_reg;
        opcode_next   = opcode_reg;
        success_next  = success_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        kind_next     = kind_reg;
        pay_next      = pay_reg;
        ecount_next   = ecount_reg;
        esucc_next    = esucc_reg;
        estatus_next  = estatus_reg;
        csum_next     = csum_reg;
        last_next     = last_reg;

        emit    = 1'b0;
        sum_in  = 1'b0;
        rkind   = KIND_PAYLOAD;
        rpay    = '0;
        rcount  = '0;
        rsucc   = '0;
        rstatus = '0;
        rcsum   = '0;
        rlast   = 1'b0;

        if (cmd_pop) begin
            unique case (cmd.op)
                OP_START: begin
                    acc_next     = '0;
                    odd_next     = 1'b1;
                    pending_next = cmd.data;
                    opcode_next  = '0;
                    success_next = '0;
                    count_next   = '0;
                    status_next  = '0;
                end
                OP_SUM: begin
                    sum_in = 1'b1;
                end
                OP_PAYLOAD: begin
                    sum_in = 1'b1;
                    emit   = 1'b1;
                    rkind  = KIND_PAYLOAD;
                    rpay   = cmd.data;
                end
                OP_CTRL_BYTE: begin
                    sum_in = 1'b1;
                    unique case (cmd.idx)
                        CIDX_OPCODE:    opcode_next  = cmd.data;
                        CIDX_SUCCESS:   success_next = cmd.data;
                        CIDX_COUNT_LO:  count_next   = {count_reg[15:8], cmd.data};
                        CIDX_COUNT_HI:  count_next   = {cmd.data, count_reg[7:0]};
                        CIDX_STATUS_LO: status_next  = {status_reg[15:8], cmd.data};
                        CIDX_STATUS_HI: status_next  = {cmd.data, status_reg[7:0]};
                        default: ;
                    endcase
                end
                OP_CHECK_LO: begin
                    if (odd_reg) begin
                        acc_next = folded_sum;
                    end
                    odd_next      = 1'b0;
                    check_lo_next = cmd.data;
                end
                OP_DATA_CHECK: begin
                    emit  = 1'b1;
                    rkind = sum_match ? KIND_DATA_OK : KIND_DATA_BAD;
                    rcsum = acc_reg;
                    rlast = 1'b1;
                end
                OP_CTRL_CHECK: begin
                    emit  = 1'b1;
                    rcsum = acc_reg;
                    rlast = 1'b1;
                    if (!sum_match) begin
                        rkind = KIND_CTRL_BAD;
                    end else if (opcode_reg == OPCODE_END) begin
                        rkind   = KIND_END_OK;
                        rcount  = count_reg;
                        rsucc   = success_reg;
                        rstatus = status_reg;
                    end else begin
                        rkind = KIND_CTRL_NOTEND;
                    end
                end
                OP_FLAG_CONTINUE: begin
                    emit  = 1'b1;
                    rkind = KIND_CONTINUE;
                    rlast = 1'b1;
                end
                OP_FLAG_INIT: begin
                    emit  = 1'b1;
                    rkind = KIND_INIT;
                    rlast = 1'b1;
                end
                OP_FLAG_BAD: begin
                    emit  = 1'b1;
                    rkind = KIND_UNEXPECTED;
                    rlast = 1'b1;
                end
                default: ;
            endcase
        end

        // Pair bytes into little-endian words
        if (sum_in) begin
            if (!odd_reg) begin
                pending_next = cmd.data;
                odd_next     = 1'b1;
            end else begin
                acc_next = folded_sum;
                odd_next = 1'b0;
            end
        end

        if (emit) begin
            out_valid_next = 1'b1;
            kind_next      = rkind;
            pay_next       = rpay;
            ecount_next    = rcount;
            esucc_next     = rsucc;
            estatus_next   = rstatus;
            csum_next      = rcsum;
            last_next      = rlast;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_kind              = kind_reg;
    assign m_payload_byte      = pay_reg;
    assign m_end_byte_count    = ecount_reg;
    assign m_end_success_code  = esucc_reg;
    assign m_end_status        = estatus_reg;
    assign m_computed_checksum = csum_reg;
    assign m_last              = last_reg;

endmodule
